FILE: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// Software timer table package
// Types and codes shared by the timer table and its storage modules.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int REPS_W   = 16;
    localparam int STATUS_W = 3;
    localparam int ACTIVE_W = 5;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_DUP      = 3'd3,
        ST_NONE     = 3'd4
    } status_t;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_FIRE_RD,
        S_FIRE_OUT,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] period;
        logic [REPS_W-1:0] repeats;
        logic [TIME_W-1:0] start;
    } entry_t;

endpackage

FILE: design/software_timer_table.sv
// ----------------------------------------------------------------------------
// Software timer table
// Packed table of software timers with create, add, remove and update.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel carries an operation and the current
// millisecond time. Create and add append a timer, remove deletes the first
// timer with the given id, and update checks every timer for expiry.
// Results leave on the m_ channel. Update sends one fire result per expired
// timer, then one reply; every other operation sends a single reply. The last
// result of a request has m_last_result set, and all results of a request
// carry the table size after that request.
// Timing: the table lives in a memory with registered read data. A scan
// reads one entry per cycle; remove and update write the kept entries back
// compacted, while add only checks the entries for a duplicate id. Create
// does not scan the table. One request is in
// flight at a time; s_ready is high only between requests.
// Reset clears the table size; the entry memory itself is not cleared.
// A stalled receiver simply holds the current result, and the block waits.
// ----------------------------------------------------------------------------
module software_timer_table #(
    parameter int MAX_TIMERS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_operation,
    input  logic [7:0]   s_timer_id,
    input  logic [31:0]  s_period_ms,
    input  logic [15:0]  s_repeat_count,
    input  logic [31:0]  s_now_time,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_result_kind,
    output logic [2:0]   m_status,
    output logic [7:0]   m_fired_id,
    output logic [4:0]   m_active_count,
    output logic         m_last_result
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    stt_pkg::state_t  state_reg, state_next;
    stt_pkg::op_t     op_reg, op_next;
    stt_pkg::status_t status_reg, status_next;
    logic [7:0]       id_reg, id_next;
    logic [31:0]      period_reg, period_next;
    logic [15:0]      reps_reg, reps_next;
    logic [31:0]      now_reg, now_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    logic [CNT_W-1:0] fptr_reg, fptr_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;

    // Entry memory port signals.
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    stt_pkg::entry_t  ram_wdata, ram_rdata;

    // Fired id buffer port signals.
    logic             fire_we, fire_re;
    logic [7:0]       fire_rdata;

    logic             full;
    logic [32:0]      end_time;
    logic             expired;
    logic             id_match;

    stt_entry_ram #(.DEPTH(MAX_TIMERS), .ADDR_W(IDX_W)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    stt_fire_ram #(.DEPTH(MAX_TIMERS), .ADDR_W(IDX_W)) u_fire_ram (
        .aclk    (aclk),
        .wr_en   (fire_we),
        .wr_addr (fcnt_reg[IDX_W-1:0]),
        .wr_data (ram_rdata.id),
        .rd_en   (fire_re),
        .rd_addr (fptr_reg[IDX_W-1:0]),
        .rd_data (fire_rdata)
    );

    assign full     = (count_reg >= CNT_W'(MAX_TIMERS));
    assign end_time = {1'b0, now_reg} + {1'b0, period_reg};
    assign expired  = ((now_reg - ram_rdata.start) >= ram_rdata.period);
    assign id_match = (ram_rdata.id == id_reg);
    assign ram_raddr = rd_idx_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        op_reg     <= op_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        period_reg <= period_next;
        reps_reg   <= reps_next;
        now_reg    <= now_next;
        rd_idx_reg <= rd_idx_next;
        wptr_reg   <= wptr_next;
        fcnt_reg   <= fcnt_next;
        fptr_reg   <= fptr_next;
        hit_reg    <= hit_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (stt_pkg::op_t'(s_operation) == stt_pkg::OP_CREATE)
                               ? stt_pkg::S_FINISH : stt_pkg::S_SCAN;
                end
            end
            stt_pkg::S_SCAN: begin
                if (rd_idx_reg == count_reg && !pend_reg) begin
                    state_next = stt_pkg::S_FINISH;
                end
            end
            stt_pkg::S_FINISH: begin
                state_next = (op_reg == stt_pkg::OP_UPDATE && fcnt_reg != '0)
                           ? stt_pkg::S_FIRE_RD : stt_pkg::S_REPLY;
            end
            stt_pkg::S_FIRE_RD: begin
                state_next = stt_pkg::S_FIRE_OUT;
            end
            stt_pkg::S_FIRE_OUT: begin
                if (m_ready) begin
                    state_next = (fptr_reg + CNT_W'(1) == fcnt_reg)
                               ? stt_pkg::S_REPLY : stt_pkg::S_FIRE_RD;
                end
            end
            stt_pkg::S_REPLY: begin
                if (m_ready) begin
                    state_next = stt_pkg::S_IDLE;
                end
            end
            default: state_next = stt_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        op_next     = op_reg;
        status_next = status_reg;
        id_next     = id_reg;
        period_next = period_reg;
        reps_next   = reps_reg;
        now_next    = now_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wptr_next   = wptr_reg;
        fcnt_next   = fcnt_reg;
        fptr_next   = fptr_reg;
        pend_next   = 1'b0;
        hit_next    = hit_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = wptr_reg[IDX_W-1:0];
        ram_wdata   = ram_rdata;
        fire_we     = 1'b0;
        fire_re     = 1'b0;
        case (state_reg)
            stt_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next     = stt_pkg::op_t'(s_operation);
                    id_next     = s_timer_id;
                    period_next = s_period_ms;
                    reps_next   = s_repeat_count;
                    now_next    = s_now_time;
                    rd_idx_next = '0;
                    wptr_next   = '0;
                    fcnt_next   = '0;
                    fptr_next   = '0;
                    hit_next    = 1'b0;
                end
            end
            stt_pkg::S_SCAN: begin
                if (rd_idx_reg < count_reg) begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    case (op_reg)
                        stt_pkg::OP_ADD: begin
                            if (id_match) begin
                                hit_next = 1'b1;
                            end
                        end
                        stt_pkg::OP_REMOVE: begin
                            // The first matching entry is dropped; the entries
                            // after it are written back one slot lower.
                            if (id_match && !hit_reg) begin
                                hit_next = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                wptr_next = wptr_reg + CNT_W'(1);
                            end
                        end
                        stt_pkg::OP_UPDATE: begin
                            if (expired) begin
                                fire_we   = 1'b1;
                                fcnt_next = fcnt_reg + CNT_W'(1);
                                ram_wdata.start = now_reg;
                                if (ram_rdata.repeats > 16'd1) begin
                                    ram_wdata.repeats = ram_rdata.repeats - 16'd1;
                                end
                            end
                            // A timer on its last firing retires.
                            if (!(expired && ram_rdata.repeats == 16'd1)) begin
                                ram_we    = 1'b1;
                                wptr_next = wptr_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stt_pkg::S_FINISH: begin
                ram_waddr         = count_reg[IDX_W-1:0];
                ram_wdata.id      = id_reg;
                ram_wdata.period  = period_reg;
                ram_wdata.repeats = reps_reg;
                ram_wdata.start   = now_reg;
                case (op_reg)
                    stt_pkg::OP_CREATE, stt_pkg::OP_ADD: begin
                        if (full) begin
                            status_next = stt_pkg::ST_FULL;
                        end else if (op_reg == stt_pkg::OP_ADD && hit_reg) begin
                            status_next = stt_pkg::ST_DUP;
                        end else if (end_time[32]) begin
                            status_next = stt_pkg::ST_OVERFLOW;
                        end else begin
                            status_next = stt_pkg::ST_OK;
                            ram_we      = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    stt_pkg::OP_REMOVE: begin
                        status_next = hit_reg ? stt_pkg::ST_OK : stt_pkg::ST_NONE;
                        count_next  = wptr_reg;
                    end
                    default: begin
                        status_next = (count_reg == '0) ? stt_pkg::ST_NONE
                                                        : stt_pkg::ST_OK;
                        count_next  = wptr_reg;
                    end
                endcase
            end
            stt_pkg::S_FIRE_RD: begin
                fire_re = 1'b1;
            end
            stt_pkg::S_FIRE_OUT: begin
                if (m_ready) begin
                    fptr_next = fptr_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Port outputs.
    always_comb begin
        s_ready        = (state_reg == stt_pkg::S_IDLE);
        m_valid        = 1'b0;
        m_result_kind  = stt_pkg::KIND_REPLY;
        m_status       = status_reg;
        m_fired_id     = (op_reg == stt_pkg::OP_UPDATE) ? 8'd0 : id_reg;
        m_active_count = 5'(count_reg);
        m_last_result  = 1'b0;
        case (state_reg)
            stt_pkg::S_FIRE_OUT: begin
                m_valid       = 1'b1;
                m_result_kind = stt_pkg::KIND_FIRE;
                m_status      = stt_pkg::ST_OK;
                m_fired_id    = fire_rdata;
            end
            stt_pkg::S_REPLY: begin
                m_valid       = 1'b1;
                m_last_result = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: design/stt_entry_ram.sv
// ----------------------------------------------------------------------------
// Timer entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_entry_ram #(
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  stt_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output stt_pkg::entry_t      rd_data
);

    stt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/stt_fire_ram.sv
// ----------------------------------------------------------------------------
// Fired id buffer
// Holds the ids of timers that expired during a scan until they are sent.
// ----------------------------------------------------------------------------
module stt_fire_ram #(
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [stt_pkg::ID_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [stt_pkg::ID_W-1:0] rd_data
);

    logic [stt_pkg::ID_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
